### src/alq_pkg.sv
// Shared constants and types for the linear and quadratic array resampler.
package alq_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_OUTPUTS = 64;
    localparam int FRAC_BITS   = 16;

    localparam int ADDR_W   = $clog2(MAX_SAMPLES);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int IDX_W    = $clog2(MAX_OUTPUTS);
    localparam int POS_W    = ADDR_W + FRAC_BITS;
    localparam int SAMPLE_W = 24;
    localparam int VALUE_W  = 25;
    localparam int OCNT_W   = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'd1;

    localparam logic [OCNT_W-1:0] OUT_COUNT_RESET = 7'd64;
    localparam logic              MODE_RESET      = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [VALUE_W-1:0]  value_t;

endpackage

### src/alq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module alq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/array_resampler_lin_quad_top.sv
// Array resampler: loads a frame of samples, then emits linear or quadratic resampled points.
// Load: one sample per cycle, busy stays low between loads.
// After the beat flagged last: a setup state and a bit-serial divider, then for each result
// the states address, three RAM reads, three multiplies and an accumulate, output.
// Reset (async, active low) empties the frame, sets out_count to 64 and mode to quadratic.
module array_resampler_lin_quad_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  alq_pkg::sample_t                sample,
    input  logic                            last_sample,
    input  logic                            cfg_we,
    input  logic [alq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [alq_pkg::CFG_W-1:0]       cfg_data,
    output logic                            strobe,
    output alq_pkg::value_t                 value,
    output logic [alq_pkg::IDX_W-1:0]       out_index,
    output logic                            last_out
);

    import alq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_DIV, S_ADDR, S_RD0, S_RD1, S_RD2,
        S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_OUT
    } state_t;

    localparam logic [POS_W-1:0] HALF = POS_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [POS_W+1:0] QLIM = (POS_W+2)'(3) << (FRAC_BITS - 1);
    localparam logic signed [47:0] RND_LIN  = 48'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [47:0] RND_QUAD = 48'sd1 <<< (FRAC_BITS + 1);
    localparam logic signed [47:0] VAL_MAX = 48'sd16777215;
    localparam logic signed [47:0] VAL_MIN = -48'sd16777216;

    // Control registers.
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [OCNT_W-1:0]   out_count_reg, out_count_next;
    logic                mode_reg, mode_next;
    logic                strobe_reg, strobe_next;

    // Datapath registers.
    logic [POS_W-1:0]    dvd_reg, dvd_next;
    logic [IDX_W-1:0]    drem_reg, drem_next;
    logic [4:0]          bit_cnt_reg, bit_cnt_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [IDX_W-1:0]    prem_reg, prem_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic                quad_reg, quad_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [FRAC_BITS-1:0] f_reg, f_next;
    logic signed [17:0]  t_reg, t_next;
    sample_t             s0_reg, s0_next, s1_reg, s1_next, s2_reg, s2_next;
    logic signed [45:0]  prod_reg, prod_next;
    logic [16:0]         t2_reg, t2_next;
    logic signed [47:0]  acc_reg, acc_next;
    value_t              value_reg, value_next;
    logic [IDX_W-1:0]    out_index_reg, out_index_next;
    logic                last_out_reg, last_out_next;

    logic                in_take;
    logic                ram_we;
    logic [ADDR_W-1:0]   raddr;
    sample_t             rdata;

    logic [CNT_W-1:0]    nm1_full;
    logic [POS_W-1:0]    d_full;
    logic [IDX_W-1:0]    den;
    logic [IDX_W:0]      div_sh;
    logic                div_ge;
    logic [POS_W-1:0]    ph;
    logic signed [17:0]  t_half;
    logic signed [POS_W+1:0] qlim;
    logic                quad_ok;
    logic [IDX_W:0]      rsum;
    logic signed [26:0]  mul_a;
    logic signed [18:0]  mul_b;
    logic signed [47:0]  res_wide;

    assign in_take = start && !busy;
    assign ram_we  = in_take && !count_reg[CNT_W-1];

    alq_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign nm1_full = count_reg - CNT_W'(1);
    assign d_full   = {nm1_full[ADDR_W-1:0], {FRAC_BITS{1'b0}}};

    always_comb
    begin
        if (out_count_reg < OCNT_W'(2))
        begin
            den = IDX_W'(1);
        end
        else if (out_count_reg > OCNT_W'(MAX_OUTPUTS))
        begin
            den = IDX_W'(MAX_OUTPUTS - 1);
        end
        else
        begin
            den = IDX_W'(out_count_reg - OCNT_W'(1));
        end
    end

    // One restoring divider step per cycle; the dividend register collects the quotient.
    assign div_sh = {drem_reg, dvd_reg[POS_W-1]};
    assign div_ge = div_sh >= {1'b0, den};

    assign ph      = pos_reg + HALF;
    assign t_half  = $signed({2'b00, ph[FRAC_BITS-1:0]}) - $signed(18'(HALF));
    assign qlim    = $signed({2'b00, d_full}) - QLIM;
    assign quad_ok = mode_reg && (pos_reg > HALF) && ($signed({2'b00, pos_reg}) < qlim);
    assign rsum    = {1'b0, prem_reg} + {1'b0, drem_reg};

    always_comb
    begin
        unique case (state_reg)
            S_RD1:   raddr = base_reg + ADDR_W'(1);
            S_RD2:   raddr = base_reg + ADDR_W'(2);
            default: raddr = base_reg;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL0:
            begin
                if (quad_reg)
                begin
                    mul_a = 27'(t_reg);
                    mul_b = 19'(t_reg);
                end
                else
                begin
                    mul_a = (f_reg == '0) ? 27'sd0 : 27'(s1_reg) - 27'(s0_reg);
                    mul_b = $signed({3'b000, f_reg});
                end
            end
            S_MUL1:
            begin
                mul_a = 27'(s2_reg) - 27'(s0_reg);
                mul_b = 19'(t_reg);
            end
            S_MUL2:
            begin
                mul_a = 27'(s0_reg) - (27'(s1_reg) <<< 1) + 27'(s2_reg);
                mul_b = $signed({2'b00, t2_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        if (quad_reg)
        begin
            res_wide = 48'(s1_reg) + ((acc_reg + RND_QUAD) >>> (FRAC_BITS + 2));
        end
        else
        begin
            res_wide = 48'(s0_reg) + ((acc_reg + RND_LIN) >>> FRAC_BITS);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_count_next = out_count_reg;
        mode_next      = mode_reg;
        strobe_next    = 1'b0;
        dvd_next       = dvd_reg;
        drem_next      = drem_reg;
        bit_cnt_next   = bit_cnt_reg;
        pos_next       = pos_reg;
        prem_next      = prem_reg;
        j_next         = j_reg;
        quad_next      = quad_reg;
        base_next      = base_reg;
        f_next         = f_reg;
        t_next         = t_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        prod_next      = 46'(mul_a) * 46'(mul_b);
        t2_next        = t2_reg;
        acc_next       = acc_reg;
        value_next     = value_reg;
        out_index_next = out_index_reg;
        last_out_next  = last_out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OUT_COUNT: out_count_next = cfg_data;
                REG_MODE:      mode_next = cfg_data[0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (!count_reg[CNT_W-1])
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_sample)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                dvd_next     = d_full;
                drem_next    = '0;
                bit_cnt_next = '0;
                pos_next     = '0;
                prem_next    = '0;
                j_next       = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                dvd_next     = {dvd_reg[POS_W-2:0], div_ge};
                drem_next    = div_ge ? IDX_W'(div_sh - {1'b0, den}) : div_sh[IDX_W-1:0];
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'(POS_W - 1))
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                quad_next  = quad_ok;
                base_next  = quad_ok ? ph[POS_W-1:FRAC_BITS] - ADDR_W'(1)
                                     : pos_reg[POS_W-1:FRAC_BITS];
                f_next     = pos_reg[FRAC_BITS-1:0];
                t_next     = {t_half[16:0], 1'b0};
                state_next = S_RD0;
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                s0_next    = rdata;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                s1_next    = rdata;
                state_next = S_MUL0;
            end
            S_MUL0:
            begin
                s2_next    = rdata;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                // Product holds t*t in quadratic mode, the full linear term otherwise.
                t2_next = prod_reg[FRAC_BITS+16:FRAC_BITS];
                if (!quad_reg)
                begin
                    acc_next = 48'(prod_reg);
                end
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                if (quad_reg)
                begin
                    acc_next = 48'(prod_reg);
                end
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                if (quad_reg)
                begin
                    acc_next = acc_reg + 48'(prod_reg);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                strobe_next    = 1'b1;
                out_index_next = j_reg;
                last_out_next  = (j_reg == den);
                if (res_wide > VAL_MAX)
                begin
                    value_next = VAL_MAX[VALUE_W-1:0];
                end
                else if (res_wide < VAL_MIN)
                begin
                    value_next = VAL_MIN[VALUE_W-1:0];
                end
                else
                begin
                    value_next = res_wide[VALUE_W-1:0];
                end
                // Step the position by the quotient, carrying the remainder.
                if (rsum >= {1'b0, den})
                begin
                    prem_next = IDX_W'(rsum - {1'b0, den});
                    pos_next  = pos_reg + dvd_reg + POS_W'(1);
                end
                else
                begin
                    prem_next = rsum[IDX_W-1:0];
                    pos_next  = pos_reg + dvd_reg;
                end
                j_next = j_reg + IDX_W'(1);
                if (j_reg == den)
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ADDR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_count_reg <= OUT_COUNT_RESET;
            mode_reg      <= MODE_RESET;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_count_reg <= out_count_next;
            mode_reg      <= mode_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg       <= dvd_next;
        drem_reg      <= drem_next;
        bit_cnt_reg   <= bit_cnt_next;
        pos_reg       <= pos_next;
        prem_reg      <= prem_next;
        j_reg         <= j_next;
        quad_reg      <= quad_next;
        base_reg      <= base_next;
        f_reg         <= f_next;
        t_reg         <= t_next;
        s0_reg        <= s0_next;
        s1_reg        <= s1_next;
        s2_reg        <= s2_next;
        prod_reg      <= prod_next;
        t2_reg        <= t2_next;
        acc_reg       <= acc_next;
        value_reg     <= value_next;
        out_index_reg <= out_index_next;
        last_out_reg  <= last_out_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign value     = value_reg;
    assign out_index = out_index_reg;
    assign last_out  = last_out_reg;

    // A result beat that is not the last one leaves the block still working.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_out |-> busy)
        else $error("non-final result beat while idle");

    // A last flag always starts an emission run.
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_sample |=> busy)
        else $error("last sample did not start emission");

    // Result beats are separated by the per-point sequence.
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("result beats in back-to-back cycles");

    // Every run ends with the frame emptied.
    a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_out |-> count_reg == '0)
        else $error("frame not cleared after final result");

endmodule
